// File: rtl/enu_rot_pkg.sv
// Shared constants, types and helper functions for the ECEF to ENU rotation unit.
package enu_rot_pkg;

    // CORDIC iterations, one pipeline stage each
    localparam int CORDIC_STEPS = 30;

    // Datapath widths
    localparam int W_XY  = 34;
    localparam int W_Z   = 33;
    localparam int W_OUT = 32;
    localparam int W_PRD = 65;

    // Angle to phase scale factors (one turn is 2^32)
    localparam logic signed [32:0] DEG_TO_PHASE = 33'sd1527099483;
    localparam logic signed [32:0] RAD_TO_PHASE = 33'sd2734261102;

    // CORDIC start vector and unit value, Q1.30
    localparam logic signed [W_XY-1:0] CORDIC_GAIN = W_XY'(652032874);
    localparam logic signed [W_XY-1:0] ONE_Q30     = W_XY'(1073741824);

    // Quadrant codes from the top two phase bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Sine and cosine pair after quadrant fix-up
    typedef struct packed {
        logic signed [W_OUT-1:0] s;
        logic signed [W_OUT-1:0] c;
    } t_sin_cos;

    // Arctangent of 2^-k in units of 2^-32 turn
    function automatic logic signed [W_Z-1:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;  default: v = 32'h00000000;
        endcase
        return W_Z'(signed'({1'b0, v}));
    endfunction

    // Clamp to [-1, 1] in Q1.30
    function automatic logic signed [W_OUT-1:0] sat_unit(input logic signed [W_XY-1:0] v);
        logic signed [W_XY-1:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r[W_OUT-1:0];
    endfunction

    // Map the first-quadrant CORDIC result to the full turn
    function automatic t_sin_cos quad_fix(input logic signed [W_XY-1:0] x,
                                          input logic signed [W_XY-1:0] y,
                                          input logic [1:0] q);
        logic signed [W_XY-1:0] c;
        logic signed [W_XY-1:0] s;
        t_sin_cos r;
        unique case (q)
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        r.s = sat_unit(s);
        r.c = sat_unit(c);
        return r;
    endfunction

endpackage

// File: rtl/ecef_to_enu_rotation_unit.sv
// Registers to o_valid: scale, CORDIC load, CORDIC steps, fix-up, products, outputs.
// Throughput: one item per cycle; busy is never raised and every stage advances each cycle.
// Depth is set by the unrolled CORDIC, one rotation step per register stage, two in parallel.
// Reset (i_rst_n low, synchronous) clears the valid chain; data registers are not reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Top level: ECEF to east-north-up rotation matrix pipeline.
module ecef_to_enu_rotation_unit
    import enu_rot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      i_longitude,
    input  logic signed [31:0]      i_latitude,
    input  logic                    i_angle_in_radians,
    output logic                    o_valid,
    output logic signed [31:0]      o_east_x,
    output logic signed [31:0]      o_east_y,
    output logic signed [31:0]      o_east_z,
    output logic signed [31:0]      o_north_x,
    output logic signed [31:0]      o_north_y,
    output logic signed [31:0]      o_north_z,
    output logic signed [31:0]      o_up_x,
    output logic signed [31:0]      o_up_y,
    output logic signed [31:0]      o_up_z
);

    localparam int LAT = CORDIC_STEPS + 5;

    // Valid chain
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[LAT-1];

    // Stage 0: scale angles to phase
    logic signed [W_PRD-1:0] r_lon_prd;
    logic signed [W_PRD-1:0] r_lat_prd;
    logic                    r_rad;
    logic signed [32:0]      n_scale;

    assign n_scale = i_angle_in_radians ? RAD_TO_PHASE : DEG_TO_PHASE;

    always_ff @(posedge i_clk) begin
        r_lon_prd <= W_PRD'(i_longitude * n_scale);
        r_lat_prd <= W_PRD'(i_latitude * n_scale);
        r_rad     <= i_angle_in_radians;
    end

    // Stage 1: round, keep 32 phase bits, load CORDIC start vector
    logic [W_PRD-1:0] n_lon_rnd;
    logic [W_PRD-1:0] n_lat_rnd;
    logic [31:0]      n_lon_ph;
    logic [31:0]      n_lat_ph;

    always_comb begin
        n_lon_rnd = unsigned'(r_lon_prd) + (r_rad ? W_PRD'(1) << 24 : W_PRD'(1) << 29);
        n_lat_rnd = unsigned'(r_lat_prd) + (r_rad ? W_PRD'(1) << 24 : W_PRD'(1) << 29);
        n_lon_ph  = r_rad ? n_lon_rnd[56:25] : n_lon_rnd[61:30];
        n_lat_ph  = r_rad ? n_lat_rnd[56:25] : n_lat_rnd[61:30];
    end

    logic signed [W_XY-1:0] r_lon_x [0:CORDIC_STEPS];
    logic signed [W_XY-1:0] r_lon_y [0:CORDIC_STEPS];
    logic signed [W_Z-1:0]  r_lon_z [0:CORDIC_STEPS];
    logic [1:0]             r_lon_q [0:CORDIC_STEPS];
    logic signed [W_XY-1:0] r_lat_x [0:CORDIC_STEPS];
    logic signed [W_XY-1:0] r_lat_y [0:CORDIC_STEPS];
    logic signed [W_Z-1:0]  r_lat_z [0:CORDIC_STEPS];
    logic [1:0]             r_lat_q [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_lon_x[0] <= CORDIC_GAIN;
        r_lon_y[0] <= '0;
        r_lon_z[0] <= W_Z'(signed'({1'b0, n_lon_ph[29:0]}));
        r_lon_q[0] <= n_lon_ph[31:30];
        r_lat_x[0] <= CORDIC_GAIN;
        r_lat_y[0] <= '0;
        r_lat_z[0] <= W_Z'(signed'({1'b0, n_lat_ph[29:0]}));
        r_lat_q[0] <= n_lat_ph[31:30];
    end

    // CORDIC rotation stages, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [W_Z-1:0] ATAN = atan_turn(5'(i));

        always_ff @(posedge i_clk) begin
            if (r_lon_z[i] >= 0) begin
                r_lon_x[i+1] <= r_lon_x[i] - (r_lon_y[i] >>> i);
                r_lon_y[i+1] <= r_lon_y[i] + (r_lon_x[i] >>> i);
                r_lon_z[i+1] <= r_lon_z[i] - ATAN;
            end else begin
                r_lon_x[i+1] <= r_lon_x[i] + (r_lon_y[i] >>> i);
                r_lon_y[i+1] <= r_lon_y[i] - (r_lon_x[i] >>> i);
                r_lon_z[i+1] <= r_lon_z[i] + ATAN;
            end
            if (r_lat_z[i] >= 0) begin
                r_lat_x[i+1] <= r_lat_x[i] - (r_lat_y[i] >>> i);
                r_lat_y[i+1] <= r_lat_y[i] + (r_lat_x[i] >>> i);
                r_lat_z[i+1] <= r_lat_z[i] - ATAN;
            end else begin
                r_lat_x[i+1] <= r_lat_x[i] + (r_lat_y[i] >>> i);
                r_lat_y[i+1] <= r_lat_y[i] - (r_lat_x[i] >>> i);
                r_lat_z[i+1] <= r_lat_z[i] + ATAN;
            end
            r_lon_q[i+1] <= r_lon_q[i];
            r_lat_q[i+1] <= r_lat_q[i];
        end
    end

    // Quadrant fix-up and saturation
    t_sin_cos r_lon_sc;
    t_sin_cos r_lat_sc;

    always_ff @(posedge i_clk) begin
        r_lon_sc <= quad_fix(r_lon_x[CORDIC_STEPS], r_lon_y[CORDIC_STEPS],
                             r_lon_q[CORDIC_STEPS]);
        r_lat_sc <= quad_fix(r_lat_x[CORDIC_STEPS], r_lat_y[CORDIC_STEPS],
                             r_lat_q[CORDIC_STEPS]);
    end

    // Products of latitude and longitude terms
    logic signed [63:0] r_slat_clon;
    logic signed [63:0] r_slat_slon;
    logic signed [63:0] r_clat_clon;
    logic signed [63:0] r_clat_slon;
    t_sin_cos           r_lon_sc_d;
    t_sin_cos           r_lat_sc_d;

    always_ff @(posedge i_clk) begin
        r_slat_clon <= r_lat_sc.s * r_lon_sc.c;
        r_slat_slon <= r_lat_sc.s * r_lon_sc.s;
        r_clat_clon <= r_lat_sc.c * r_lon_sc.c;
        r_clat_slon <= r_lat_sc.c * r_lon_sc.s;
        r_lon_sc_d  <= r_lon_sc;
        r_lat_sc_d  <= r_lat_sc;
    end

    // Round products back to Q1.30 and form the matrix
    logic signed [63:0] n_p0;
    logic signed [63:0] n_p1;
    logic signed [63:0] n_p2;
    logic signed [63:0] n_p3;

    always_comb begin
        n_p0 = r_slat_clon + 64'sd536870912;
        n_p1 = r_slat_slon + 64'sd536870912;
        n_p2 = r_clat_clon + 64'sd536870912;
        n_p3 = r_clat_slon + 64'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        o_east_x  <= -r_lon_sc_d.s;
        o_east_y  <= r_lon_sc_d.c;
        o_north_x <= -signed'(n_p0[61:30]);
        o_north_y <= -signed'(n_p1[61:30]);
        o_north_z <= r_lat_sc_d.c;
        o_up_x    <= signed'(n_p2[61:30]);
        o_up_y    <= signed'(n_p3[61:30]);
        o_up_z    <= r_lat_sc_d.s;
    end

    assign o_east_z = '0;

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching start transfer");

    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_up_z <= 32'sd1073741824) && (o_up_z >= -32'sd1073741824))
        else $error("sine latitude out of unit range");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_east_y <= 32'sd1073741824) && (o_east_y >= -32'sd1073741824))
        else $error("cosine longitude out of unit range");

endmodule

// File: tb/sv/ecef_to_enu_rotation_unit_tb.sv
// Self-checking testbench for the ECEF to ENU rotation unit: directed and random angles.
module ecef_to_enu_rotation_unit_tb;
    import enu_rot_pkg::*;

    localparam int LATENCY     = CORDIC_STEPS + 5;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [31:0] ex, ey, ez, nx, ny, nz, ux, uy, uz;
    } t_enu_mat;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_longitude;
    logic signed [31:0] i_latitude;
    logic               i_angle_in_radians;
    logic               o_valid;
    logic signed [31:0] o_east_x, o_east_y, o_east_z;
    logic signed [31:0] o_north_x, o_north_y, o_north_z;
    logic signed [31:0] o_up_x, o_up_y, o_up_z;

    t_enu_mat matrix_queue[$];
    int       mismatch_count;
    int       cycle_count;
    bit       quiet_stretch;

    ecef_to_enu_rotation_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_longitude(i_longitude), .i_latitude(i_latitude),
        .i_angle_in_radians(i_angle_in_radians), .o_valid(o_valid),
        .o_east_x(o_east_x), .o_east_y(o_east_y), .o_east_z(o_east_z),
        .o_north_x(o_north_x), .o_north_y(o_north_y), .o_north_z(o_north_z),
        .o_up_x(o_up_x), .o_up_y(o_up_y), .o_up_z(o_up_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Angle to 32-bit phase; the wrap reduces into one turn
    function automatic logic [31:0] angle_phase(logic signed [31:0] a, logic rad);
        logic signed [95:0] p;
        if (rad) begin
            p = (96'(a) * 96'sd2734261102 + 96'sd16777216) >>> 25;
        end else begin
            p = (96'(a) * 96'sd1527099483 + 96'sd536870912) >>> 30;
        end
        return p[31:0];
    endfunction

    function automatic logic signed [63:0] clamp_unit(logic signed [63:0] v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Rotation-mode CORDIC, quadrant applied afterwards
    task automatic cordic_sin_cos(input logic [31:0] ph, output logic signed [63:0] sn,
                                  output logic signed [63:0] cs);
        logic signed [63:0] x, y, z, dx, dy, c, s;
        logic [31:0] at [32];
        at = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
               32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
               32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
               32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
               32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
               32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
               32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
               32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        x = 64'sd652032874;
        y = 0;
        z = {34'd0, ph[29:0]};
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, at[i % 32]});
            end else begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, at[i % 32]});
            end
        end
        case (ph[31:30])
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        sn = clamp_unit(s);
        cs = clamp_unit(c);
    endtask

    function automatic logic signed [31:0] q30_product(logic signed [63:0] a,
                                                       logic signed [63:0] b);
        logic signed [63:0] p;
        p = (a * b + 64'sd536870912) >>> 30;
        return p[31:0];
    endfunction

    task automatic predict_enu(input logic signed [31:0] lon, input logic signed [31:0] lat,
                               input logic rad);
        logic signed [63:0] so, co, sa, ca;
        t_enu_mat m;
        cordic_sin_cos(angle_phase(lon, rad), so, co);
        cordic_sin_cos(angle_phase(lat, rad), sa, ca);
        m.ex = -so[31:0];
        m.ey = co[31:0];
        m.ez = '0;
        m.nx = -q30_product(sa, co);
        m.ny = -q30_product(sa, so);
        m.nz = ca[31:0];
        m.ux = q30_product(ca, co);
        m.uy = q30_product(ca, so);
        m.uz = sa[31:0];
        matrix_queue.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Send one item; gaps at random unless in the quiet stretch
    task automatic send_angles(input logic signed [31:0] lon, input logic signed [31:0] lat,
                               input logic rad);
        while (!quiet_stretch && $urandom_range(99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start              <= 1'b1;
        i_longitude        <= lon;
        i_latitude         <= lat;
        i_angle_in_radians <= rad;
        do @(posedge i_clk); while (busy);
        predict_enu(lon, lat, rad);
    endtask

    // Result check at each strobe
    always @(posedge i_clk) begin
        t_enu_mat w;
        if (i_rst_n && o_valid) begin
            if (matrix_queue.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                mismatch_count++;
            end else begin
                w = matrix_queue.pop_front();
                if (o_east_x !== w.ex)  report_mismatch("east_x", o_east_x, w.ex);
                if (o_east_y !== w.ey)  report_mismatch("east_y", o_east_y, w.ey);
                if (o_east_z !== w.ez)  report_mismatch("east_z", o_east_z, w.ez);
                if (o_north_x !== w.nx) report_mismatch("north_x", o_north_x, w.nx);
                if (o_north_y !== w.ny) report_mismatch("north_y", o_north_y, w.ny);
                if (o_north_z !== w.nz) report_mismatch("north_z", o_north_z, w.nz);
                if (o_up_x !== w.ux)    report_mismatch("up_x", o_up_x, w.ux);
                if (o_up_y !== w.uy)    report_mismatch("up_y", o_up_y, w.uy);
                if (o_up_z !== w.uz)    report_mismatch("up_z", o_up_z, w.uz);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Extremes, axis angles and both unit flags
    task automatic test_directed();
        logic signed [31:0] vals [10];
        vals = '{32'sh80000000, 32'sh7FFFFFFF, 0, 1, -1, 32'sd754974720,
                 -32'sd754974720, 32'sd1509949440, 32'sd13176795, 32'sd26353589};
        for (int i = 0; i < 10; i++) begin
            send_angles(vals[i], vals[9 - i], i[0]);
        end
        send_angles(32'sd377487360, 32'sd377487360, 1'b0);
        send_angles(32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        send_angles(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    endtask

    // Mostly realistic angles, some full-range noise; one burst without gaps
    task automatic test_random();
        logic signed [31:0] lon, lat;
        for (int n = 0; n < 2000; n++) begin
            quiet_stretch = (n >= 800 && n < 1100);
            if ($urandom_range(3) == 0) begin
                lon = $urandom;
                lat = $urandom;
            end else begin
                lon = $signed($urandom_range(3019898880)) - 32'sd1509949440;
                lat = $signed($urandom_range(1509949440)) - 32'sd754974720;
            end
            send_angles(lon, lat, 1'($urandom_range(1)));
        end
        quiet_stretch = 0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        start              <= 1'b0;
        i_longitude        <= '0;
        i_latitude         <= '0;
        i_angle_in_radians <= 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;
        quiet_stretch      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (matrix_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: ecef_to_enu_rotation_unit.f
rtl/enu_rot_pkg.sv
rtl/ecef_to_enu_rotation_unit.sv
tb/sv/ecef_to_enu_rotation_unit_tb.sv
